[rtl/core/csvf_pkg.sv]
// Shared types and constants for the cascaded state-variable filter core.
// Holds register indexes, response codes, reset values and the sequencer states.
// No dependencies.
package csvf_pkg;

  // configuration port shape
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_STAGES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_COEF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN  = 3'd5;

  // response select codes
  localparam logic [1:0] FT_LOW   = 2'd0;
  localparam logic [1:0] FT_HIGH  = 2'd1;
  localparam logic [1:0] FT_BAND  = 2'd2;
  localparam logic [1:0] FT_NOTCH = 2'd3;

  // register reset values
  localparam logic [1:0]  FILTER_TYPE_RST  = FT_LOW;
  localparam logic [2:0]  EXTRA_STAGES_RST = 3'd0;
  localparam logic [15:0] FREQ_COEF_RST    = 16'd6554;
  localparam logic [15:0] DAMPING_COEF_RST = 16'd32768;
  localparam logic [15:0] INPUT_SCALE_RST  = 16'd46341;
  localparam logic [15:0] OUTPUT_GAIN_RST  = 16'd8192;

  // stage state word and shared multiplier widths
  localparam int unsigned STATE_W = 32;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned PROD_W  = 49;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOW  = 8'b0000_0010,
    ST_SCL  = 8'b0000_0100,
    ST_HIGH = 8'b0000_1000,
    ST_MHI  = 8'b0001_0000,
    ST_BAND = 8'b0010_0000,
    ST_GAIN = 8'b0100_0000,
    ST_SAT  = 8'b1000_0000
  } state_e;

endpackage

[rtl/core/cascaded_state_variable_filter_core.sv]
// Each accepted item passes all N active stages (N = 1..MAX_STAGES+1), then the output gain.
// A new item is taken only after the last leaves the saturation step, which holds while the
// output stalls; the one shared 32x17 multiplier sets this, with four products per stage and
// one for the output gain. Reset (rst_ni, async, active low) loads the register defaults and
// clears all stage state at once; after reset the block is idle and takes items.
// Cascaded state-variable filter core: sequencer, shared multiplier, stage state store.
// Depends on csvf_pkg.
module cascaded_state_variable_filter_core #(
  parameter int MAX_STAGES   = 5,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [csvf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [csvf_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  // result item channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out_o
);

  localparam int DEPTH = MAX_STAGES + 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = csvf_pkg::STATE_W;
  localparam int PW    = csvf_pkg::PROD_W;
  localparam logic signed [35:0] OUT_MAX = (36'sd1 <<< (SAMPLE_WIDTH - 1)) - 36'sd1;
  localparam logic signed [35:0] OUT_MIN = -OUT_MAX - 36'sd1;

  // saturate a wide sum to the signed 32-bit stage range
  function automatic logic signed [SW-1:0] sat32(input logic signed [35:0] v);
    logic signed [SW-1:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [1:0]                     type_q;
  logic [2:0]                     extra_q;
  logic [csvf_pkg::COEF_W-1:0]    freq_q;
  logic [csvf_pkg::COEF_W-1:0]    damp_q;
  logic [csvf_pkg::COEF_W-1:0]    scale_q;
  logic [csvf_pkg::COEF_W-1:0]    gain_q;
  logic                           clear_stages;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q  <= csvf_pkg::FILTER_TYPE_RST;
      extra_q <= csvf_pkg::EXTRA_STAGES_RST;
      freq_q  <= csvf_pkg::FREQ_COEF_RST;
      damp_q  <= csvf_pkg::DAMPING_COEF_RST;
      scale_q <= csvf_pkg::INPUT_SCALE_RST;
      gain_q  <= csvf_pkg::OUTPUT_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csvf_pkg::REG_FILTER_TYPE:  type_q  <= cfg_data_i[1:0];
        csvf_pkg::REG_EXTRA_STAGES: extra_q <= cfg_data_i[2:0];
        csvf_pkg::REG_FREQ_COEF:    freq_q  <= cfg_data_i;
        csvf_pkg::REG_DAMPING_COEF: damp_q  <= cfg_data_i;
        csvf_pkg::REG_INPUT_SCALE:  scale_q <= cfg_data_i;
        csvf_pkg::REG_OUTPUT_GAIN:  gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign clear_stages = cfg_we_i && (cfg_idx_i == csvf_pkg::REG_EXTRA_STAGES);

  // index of the last active stage, extra_stages clamped to MAX_STAGES
  logic [IDX_W-1:0] last_idx;
  assign last_idx = (int'(extra_q) > MAX_STAGES) ? IDX_W'(MAX_STAGES) : IDX_W'(extra_q);

  // sequencer and working registers
  csvf_pkg::state_e       state_q, state_d;
  logic [IDX_W-1:0]       stg_q;
  logic                   is_last;
  logic signed [SW-1:0]   x_q;
  logic signed [SW-1:0]   lo_w_q;
  logic signed [SW-1:0]   bd_w_q;
  logic signed [SW-1:0]   hi_q;
  logic signed [33:0]     t_q;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic                   out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q;

  assign is_last = (stg_q == last_idx);

  // stage state store, one read port at a sequencer-chosen index
  logic signed [SW-1:0] low_q  [DEPTH];
  logic signed [SW-1:0] band_q [DEPTH];
  logic [IDX_W-1:0]     rd_idx;
  logic signed [SW-1:0] rd_low;
  logic signed [SW-1:0] rd_band;

  always_comb begin
    if (state_q == csvf_pkg::ST_IDLE) begin
      rd_idx = '0;
    end else if (state_q == csvf_pkg::ST_BAND && !is_last) begin
      rd_idx = stg_q + IDX_W'(1);
    end else begin
      rd_idx = stg_q;
    end
  end

  assign rd_low  = low_q[rd_idx];
  assign rd_band = band_q[rd_idx];

  // shared multiplier operand select
  logic signed [SW-1:0]          mul_a;
  logic [csvf_pkg::COEF_W-1:0]   mul_b;
  logic signed [csvf_pkg::COEF_W:0] mul_b_s;

  always_comb begin
    case (state_q)
      csvf_pkg::ST_IDLE: begin
        mul_a = rd_band;
        mul_b = freq_q;
      end
      csvf_pkg::ST_LOW: begin
        mul_a = x_q;
        mul_b = scale_q;
      end
      csvf_pkg::ST_SCL: begin
        mul_a = bd_w_q;
        mul_b = damp_q;
      end
      csvf_pkg::ST_MHI: begin
        mul_a = hi_q;
        mul_b = freq_q;
      end
      csvf_pkg::ST_BAND: begin
        mul_a = rd_band;
        mul_b = freq_q;
      end
      csvf_pkg::ST_GAIN: begin
        mul_a = x_q;
        mul_b = gain_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = gain_q;
      end
    endcase
  end

  assign mul_b_s = $signed({1'b0, mul_b});
  assign prod_d  = mul_a * mul_b_s;

  // floor shifts of the registered product
  logic signed [32:0] prod_sh16;
  logic signed [35:0] prod_sh13;
  assign prod_sh16 = prod_q[PW-1:16];
  assign prod_sh13 = prod_q[PW-1:13];

  // stage arithmetic
  logic signed [SW-1:0] lo_new;
  logic signed [33:0]   t_new;
  logic signed [SW-1:0] hi_new;
  logic signed [SW-1:0] bd_new;
  logic signed [SW-1:0] nt_new;
  logic signed [SW-1:0] resp;
  logic signed [SW-1:0] x_in;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  assign lo_new = sat32(36'(lo_w_q) + 36'(prod_sh16));
  assign t_new  = 34'(prod_sh16) - 34'(lo_w_q);
  assign hi_new = sat32(36'(t_q) - 36'(prod_sh16));
  assign bd_new = sat32(36'(prod_sh16) + 36'(bd_w_q));
  assign nt_new = sat32(36'(hi_q) + 36'(lo_w_q));
  assign x_in   = SW'(sample_in_i);

  always_comb begin
    case (type_q)
      csvf_pkg::FT_LOW:  resp = lo_w_q;
      csvf_pkg::FT_HIGH: resp = hi_q;
      csvf_pkg::FT_BAND: resp = bd_new;
      default:           resp = nt_new;
    endcase
  end

  // output gain saturation
  always_comb begin
    if (prod_sh13 > OUT_MAX) begin
      y_sat = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (prod_sh13 < OUT_MIN) begin
      y_sat = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = prod_sh13[SAMPLE_WIDTH-1:0];
    end
  end

  // next state
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      csvf_pkg::ST_IDLE: if (in_valid_i) state_d = csvf_pkg::ST_LOW;
      csvf_pkg::ST_LOW:  state_d = csvf_pkg::ST_SCL;
      csvf_pkg::ST_SCL:  state_d = csvf_pkg::ST_HIGH;
      csvf_pkg::ST_HIGH: state_d = csvf_pkg::ST_MHI;
      csvf_pkg::ST_MHI:  state_d = csvf_pkg::ST_BAND;
      csvf_pkg::ST_BAND: state_d = is_last ? csvf_pkg::ST_GAIN : csvf_pkg::ST_LOW;
      csvf_pkg::ST_GAIN: state_d = csvf_pkg::ST_SAT;
      csvf_pkg::ST_SAT:  if (out_free) state_d = csvf_pkg::ST_IDLE;
      default:           state_d = csvf_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csvf_pkg::ST_IDLE;
      stg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == csvf_pkg::ST_IDLE) begin
        stg_q <= '0;
      end else if (state_q == csvf_pkg::ST_BAND && !is_last) begin
        stg_q <= stg_q + IDX_W'(1);
      end
      if (state_q == csvf_pkg::ST_SAT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      csvf_pkg::ST_IDLE: begin
        x_q    <= x_in;
        lo_w_q <= rd_low;
        bd_w_q <= rd_band;
      end
      csvf_pkg::ST_LOW:  lo_w_q <= lo_new;
      csvf_pkg::ST_SCL:  t_q    <= t_new;
      csvf_pkg::ST_HIGH: hi_q   <= hi_new;
      csvf_pkg::ST_BAND: begin
        x_q    <= resp;
        lo_w_q <= rd_low;
        bd_w_q <= rd_band;
      end
      csvf_pkg::ST_SAT: if (out_free) out_data_q <= y_sat;
      default: ;
    endcase
  end

  // stage state store write back, cleared on a stage count write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        low_q[i]  <= '0;
        band_q[i] <= '0;
      end
    end else if (clear_stages) begin
      for (int i = 0; i < DEPTH; i++) begin
        low_q[i]  <= '0;
        band_q[i] <= '0;
      end
    end else if (state_q == csvf_pkg::ST_BAND) begin
      low_q[stg_q]  <= lo_w_q;
      band_q[stg_q] <= bd_new;
    end
  end

  assign in_stall_o   = (state_q != csvf_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

`ifndef ASSERT_OFF
  // an accepted item always starts the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == csvf_pkg::ST_LOW))
    else $error("accepted item did not start stage processing");

  // the stage counter never runs past the last active stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != csvf_pkg::ST_IDLE) |-> (stg_q <= last_idx))
    else $error("stage counter beyond last active stage");

  // a result only appears after the gain saturation step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == csvf_pkg::ST_SAT))
    else $error("result valid without finishing an item");

  // leaving the saturation step always loads the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csvf_pkg::ST_SAT && out_free) |=>
      (out_valid_q && state_q == csvf_pkg::ST_IDLE))
    else $error("finished item not delivered to output register");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the cascaded state-variable filter core.
// Runs a directed table, then random config phases and samples, and checks results.
// Depends on csvf_pkg and cascaded_state_variable_filter_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGE_LIMIT  = 5;
  localparam int SW           = 16;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 40;

  // indexes with no register behind them
  localparam logic [csvf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [csvf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // one row of the directed table: a register write or a sample
  typedef struct {
    bit                               is_write;
    logic [csvf_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [csvf_pkg::CFG_DATA_W-1:0]  wdata;
    logic signed [SW-1:0]             smp;
    bit                               known;
    logic signed [SW-1:0]             known_out;
  } row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [csvf_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [csvf_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic signed [SW-1:0]             sample_in_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic signed [SW-1:0]             sample_out_o;

  // mirror of the block's registers and stage state
  logic [1:0]             m_type;
  logic [2:0]             m_stages;
  logic [15:0]            m_freq;
  logic [15:0]            m_damp;
  logic [15:0]            m_scale;
  logic [15:0]            m_gain;
  logic signed [31:0]     lp_state [0:STAGE_LIMIT];
  logic signed [31:0]     bp_state [0:STAGE_LIMIT];

  logic signed [SW-1:0]   expected_samples [$];
  row_t                   plan [$];
  int                     errors;
  int                     gap_pct;
  int                     stall_pct;

  cascaded_state_variable_filter_core #(
    .MAX_STAGES   (STAGE_LIMIT),
    .SAMPLE_WIDTH (SW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // run one sample through the active stages and the output gain, updating state
  function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] smp);
    longint fq, dq, sc, gn, lo, bd, hi, nt, x, y;
    int     last;
    fq = m_freq;
    dq = m_damp;
    sc = m_scale;
    gn = m_gain;
    x  = smp;
    last = (m_stages > STAGE_LIMIT) ? STAGE_LIMIT : m_stages;
    for (int k = 0; k <= last; k++) begin
      lo = lp_state[k];
      bd = bp_state[k];
      lo = sat32(lo + ((fq * bd) >>> 16));
      hi = sat32(((sc * x) >>> 16) - lo - ((dq * bd) >>> 16));
      bd = sat32(((fq * hi) >>> 16) + bd);
      nt = sat32(hi + lo);
      lp_state[k] = lo[31:0];
      bp_state[k] = bd[31:0];
      case (m_type)
        csvf_pkg::FT_LOW:  x = lo;
        csvf_pkg::FT_HIGH: x = hi;
        csvf_pkg::FT_BAND: x = bd;
        default:           x = nt;
      endcase
    end
    y = (x * gn) >>> 13;
    if (y > 64'sd32767) y = 32767;
    if (y < -64'sd32768) y = -32768;
    return y[SW-1:0];
  endfunction

  // directed table builders
  function automatic void add_write(input logic [csvf_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] data);
    row_t r;
    r = '{1'b1, idx, data, '0, 1'b0, '0};
    plan.push_back(r);
  endfunction

  function automatic void add_sample(input logic signed [SW-1:0] v);
    row_t r;
    r = '{1'b0, '0, '0, v, 1'b0, '0};
    plan.push_back(r);
  endfunction

  function automatic void add_known(input logic signed [SW-1:0] v,
                                    input logic signed [SW-1:0] e);
    row_t r;
    r = '{1'b0, '0, '0, v, 1'b1, e};
    plan.push_back(r);
  endfunction

  // coefficient with its extremes mixed in
  function automatic logic [15:0] pick_coef(input int lo, input int hi);
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // stop sending, then wait until all results are in
  task automatic drain();
    in_valid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [csvf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      csvf_pkg::REG_FILTER_TYPE:  m_type = data[1:0];
      csvf_pkg::REG_EXTRA_STAGES: begin
        m_stages = data[2:0];
        for (int k = 0; k <= STAGE_LIMIT; k++) begin
          lp_state[k] = '0;
          bp_state[k] = '0;
        end
      end
      csvf_pkg::REG_FREQ_COEF:    m_freq  = data;
      csvf_pkg::REG_DAMPING_COEF: m_damp  = data;
      csvf_pkg::REG_INPUT_SCALE:  m_scale = data;
      csvf_pkg::REG_OUTPUT_GAIN:  m_gain  = data;
      default: ;
    endcase
  endtask

  // send one item, then record its expected result
  task automatic send_sample(input logic signed [SW-1:0] v, input bit known,
                             input logic signed [SW-1:0] known_out);
    logic signed [SW-1:0] pred;
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = filter_sample(v);
    expected_samples.push_back(known ? known_out : pred);
  endtask

  // random config phase; the first one writes every register
  task automatic random_config(input bit every_reg);
    drain();
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    if (every_reg || $urandom_range(1))
      write_reg(csvf_pkg::REG_FILTER_TYPE, 16'($urandom));
    if (every_reg || $urandom_range(2) == 0)
      write_reg(csvf_pkg::REG_EXTRA_STAGES,
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(7)));
    if (every_reg || $urandom_range(1))
      write_reg(csvf_pkg::REG_FREQ_COEF, pick_coef(100, 24000));
    if (every_reg || $urandom_range(1))
      write_reg(csvf_pkg::REG_DAMPING_COEF, pick_coef(4000, 65535));
    if (every_reg || $urandom_range(1))
      write_reg(csvf_pkg::REG_INPUT_SCALE, pick_coef(16384, 65535));
    if (every_reg || $urandom_range(1))
      write_reg(csvf_pkg::REG_OUTPUT_GAIN, pick_coef(2048, 24576));
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    logic signed [SW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected sample_out %0d at %0t", sample_out_o, $time);
      end else begin
        want = expected_samples.pop_front();
        if (sample_out_o !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("sample_out mismatch: expected %0d, got %0d at %0t",
                     want, sample_out_o, $time);
        end
      end
    end
  end

  // stimulus
  initial begin
    int                   sent;
    int                   phase_len;
    logic signed [SW-1:0] v;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    sample_in_i <= '0;
    out_stall_i <= 1'b0;
    errors    = 0;
    gap_pct   = 25;
    stall_pct = 53;
    m_type   = csvf_pkg::FILTER_TYPE_RST;
    m_stages = csvf_pkg::EXTRA_STAGES_RST;
    m_freq   = csvf_pkg::FREQ_COEF_RST;
    m_damp   = csvf_pkg::DAMPING_COEF_RST;
    m_scale  = csvf_pkg::INPUT_SCALE_RST;
    m_gain   = csvf_pkg::OUTPUT_GAIN_RST;
    for (int k = 0; k <= STAGE_LIMIT; k++) begin
      lp_state[k] = '0;
      bp_state[k] = '0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // after reset the lowpass output starts from a zero band value
    add_known(16'sh7FFF, 16'sh0000);
    add_sample(16'sh8000);
    add_sample(16'sh0000);
    add_sample(16'sh7FFF);
    // highpass, full input scale, fresh state: negative full scale passes through
    add_write(csvf_pkg::REG_FILTER_TYPE, 16'(csvf_pkg::FT_HIGH));
    add_write(csvf_pkg::REG_INPUT_SCALE, 16'hFFFF);
    add_write(csvf_pkg::REG_EXTRA_STAGES, 16'h0000);
    add_known(16'sh8000, 16'sh8000);
    // largest gain saturates the output both ways
    add_write(csvf_pkg::REG_OUTPUT_GAIN, 16'hFFFF);
    add_write(csvf_pkg::REG_EXTRA_STAGES, 16'h0000);
    add_known(16'sh7FFF, 16'sh7FFF);
    add_known(16'sh8000, 16'sh8000);
    // zero gain silences everything
    add_write(csvf_pkg::REG_OUTPUT_GAIN, 16'h0000);
    add_known(16'sh3039, 16'sh0000);
    // oversized values keep low bits; stage count above the limit is clamped
    add_write(csvf_pkg::REG_OUTPUT_GAIN, csvf_pkg::OUTPUT_GAIN_RST);
    add_write(csvf_pkg::REG_FILTER_TYPE, 16'hFFFE);
    add_write(csvf_pkg::REG_EXTRA_STAGES, 16'hFFFF);
    add_sample(16'sh7FFF);
    add_sample(16'sh8000);
    add_sample(16'sh0001);
    add_sample(-16'sh0001);
    // writes to indexes with no register are dropped
    add_write(REG_SPARE_A, 16'h0000);
    add_write(REG_SPARE_B, 16'hFFFF);
    add_sample(16'sh0064);
    add_write(csvf_pkg::REG_FILTER_TYPE, 16'(csvf_pkg::FT_NOTCH));
    add_sample(16'sh4000);
    add_sample(-16'sh4000);
    // undamped six-stage bandpass driven at resonance to saturate the stages
    add_write(csvf_pkg::REG_DAMPING_COEF, 16'h0000);
    add_write(csvf_pkg::REG_FREQ_COEF, 16'hFFFF);
    add_write(csvf_pkg::REG_FILTER_TYPE, 16'(csvf_pkg::FT_BAND));
    add_write(csvf_pkg::REG_EXTRA_STAGES, 16'd5);
    for (int k = 0; k < 10; k++)
      add_sample((k % 6) < 3 ? 16'sh7FFF : 16'sh8000);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].wdata);
      end else begin
        send_sample(plan[i].smp, plan[i].known, plan[i].known_out);
      end
    end

    // random phases: new settings, then a burst of samples
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        gap_pct   = 25;
        stall_pct = 53;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        gap_pct   = 53;
        stall_pct = 25;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      random_config(sent == 0);
      phase_len = $urandom_range(60, 8);
      for (int n = 0; n < phase_len; n++) begin
        case ($urandom_range(9))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2, 3:    v = 16'($urandom_range(512)) - 16'sd256;
          default: v = 16'($urandom);
        endcase
        send_sample(v, 1'b0, '0);
        sent++;
      end
    end

    // wait out the last results, then a quiet tail for stray ones
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
rtl/core/csvf_pkg.sv
rtl/core/cascaded_state_variable_filter_core.sv
tb/tb.sv
